// ===== rtl/udgc_pkg.sv =====
package udgc_pkg;

	// grid and number format
	localparam int GRID_SIDE = 64;
	localparam int FRAC_BITS = 8;
	localparam int PT_W = 14;
	localparam int COORD_W = $clog2(GRID_SIDE);
	localparam int ADDR_W = 2 * COORD_W;
	localparam int MAP_DEPTH = GRID_SIDE * GRID_SIDE;
	localparam int FRAC_ONE = 1 << FRAC_BITS;
	localparam int SQ_W = 2 * FRAC_BITS + 1;
	localparam int D2_W = SQ_W + 1;

	// epoch tags stored in the center map, zero means never marked
	localparam int EPOCH_W = 8;
	localparam int EPOCH_MAX = (1 << EPOCH_W) - 1;

	// queue between front and back
	localparam int Q_DEPTH = 4;
	localparam int Q_PTR_W = $clog2(Q_DEPTH);
	localparam int Q_CNT_W = $clog2(Q_DEPTH + 1);

	typedef logic [COORD_W-1:0] coord_t;
	typedef logic [EPOCH_W-1:0] epoch_t;
	typedef logic [ADDR_W-1:0] addr_t;

	localparam coord_t EDGE_CELL = coord_t'(GRID_SIDE - 1);
	localparam logic [D2_W-1:0] D2_ONE = D2_W'(FRAC_ONE * FRAC_ONE);
	localparam epoch_t EPOCH_FIRST = epoch_t'(1);
	localparam epoch_t EPOCH_LAST = epoch_t'(EPOCH_MAX);
	localparam addr_t WIPE_LAST = addr_t'(MAP_DEPTH - 1);

	// classified point handed from front to back
	typedef struct packed {
		coord_t ax;
		coord_t ay;
		coord_t bx;
		coord_t by;
		logic in_a;
		logic in_b;
		epoch_t epoch;
		logic act;
		logic wipe;
	} cand_t;

	typedef enum logic {
		BK_WIPE,
		BK_RUN
	} bk_state_t;

endpackage

// ===== rtl/udgc_front.sv =====
module udgc_front (
	input logic clk,
	input logic arst_n,
	input logic in_valid,
	output logic in_stall,
	input logic new_set,
	input logic [udgc_pkg::PT_W-1:0] point_x,
	input logic [udgc_pkg::PT_W-1:0] point_y,
	input logic wiping,
	input logic q_full,
	output logic push,
	output udgc_pkg::cand_t push_item
);

	logic valid_s1;
	logic [udgc_pkg::PT_W-1:0] x_s1;
	logic [udgc_pkg::PT_W-1:0] y_s1;
	udgc_pkg::epoch_t epoch_s1;
	logic wipe_s1;
	udgc_pkg::epoch_t epoch_q;
	udgc_pkg::epoch_t epoch_nxt;
	logic wipe_nxt;
	logic accept;

	udgc_pkg::coord_t cx;
	udgc_pkg::coord_t cy;
	logic [udgc_pkg::FRAC_BITS:0] fx_lo;
	logic [udgc_pkg::FRAC_BITS:0] fx_hi;
	logic [udgc_pkg::FRAC_BITS:0] fy_lo;
	logic [udgc_pkg::FRAC_BITS:0] fy_hi;
	logic [udgc_pkg::SQ_W-1:0] sqx_lo;
	logic [udgc_pkg::SQ_W-1:0] sqx_hi;
	logic [udgc_pkg::SQ_W-1:0] sqy_lo;
	logic [udgc_pkg::SQ_W-1:0] sqy_hi;
	logic [udgc_pkg::D2_W-1:0] d2_a;
	logic [udgc_pkg::D2_W-1:0] d2_b;
	logic odd;
	logic ax_hi;
	logic ay_hi;
	logic drop;

	// input handshake
	assign in_stall = wiping || (valid_s1 && q_full);
	assign accept = in_valid && !in_stall;

	// a new set moves to a fresh epoch, wrapping asks the back for a wipe
	always_comb begin
		epoch_nxt = epoch_q;
		wipe_nxt = 1'b0;
		if (new_set) begin
			if (epoch_q == udgc_pkg::EPOCH_LAST) begin
				epoch_nxt = udgc_pkg::EPOCH_FIRST;
				wipe_nxt = 1'b1;
			end else begin
				epoch_nxt = epoch_q + 1'b1;
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
			epoch_q <= udgc_pkg::EPOCH_FIRST;
		end else if (accept) begin
			valid_s1 <= 1'b1;
			epoch_q <= epoch_nxt;
		end else if (!q_full) begin
			valid_s1 <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (accept) begin
			x_s1 <= point_x;
			y_s1 <= point_y;
			epoch_s1 <= epoch_nxt;
			wipe_s1 <= wipe_nxt;
		end
	end

	// cell, fraction offsets to both sides of the cell
	assign cx = x_s1[udgc_pkg::PT_W-1:udgc_pkg::FRAC_BITS];
	assign cy = y_s1[udgc_pkg::PT_W-1:udgc_pkg::FRAC_BITS];
	assign fx_lo = {1'b0, x_s1[udgc_pkg::FRAC_BITS-1:0]};
	assign fy_lo = {1'b0, y_s1[udgc_pkg::FRAC_BITS-1:0]};
	assign fx_hi = (udgc_pkg::FRAC_BITS+1)'(udgc_pkg::FRAC_ONE) - fx_lo;
	assign fy_hi = (udgc_pkg::FRAC_BITS+1)'(udgc_pkg::FRAC_ONE) - fy_lo;

	assign sqx_lo = udgc_pkg::SQ_W'(fx_lo) * udgc_pkg::SQ_W'(fx_lo);
	assign sqx_hi = udgc_pkg::SQ_W'(fx_hi) * udgc_pkg::SQ_W'(fx_hi);
	assign sqy_lo = udgc_pkg::SQ_W'(fy_lo) * udgc_pkg::SQ_W'(fy_lo);
	assign sqy_hi = udgc_pkg::SQ_W'(fy_hi) * udgc_pkg::SQ_W'(fy_hi);

	// even-sum diagonal; corner b sits opposite corner a
	assign odd = cx[0] ^ cy[0];
	assign ax_hi = odd && !cx[0];
	assign ay_hi = odd && cx[0];

	assign d2_a = udgc_pkg::D2_W'(ax_hi ? sqx_hi : sqx_lo)
		+ udgc_pkg::D2_W'(ay_hi ? sqy_hi : sqy_lo);
	assign d2_b = udgc_pkg::D2_W'(ax_hi ? sqx_lo : sqx_hi)
		+ udgc_pkg::D2_W'(ay_hi ? sqy_lo : sqy_hi);

	assign drop = (cx >= udgc_pkg::EDGE_CELL) || (cy >= udgc_pkg::EDGE_CELL);

	// classified item into the queue
	always_comb begin
		push_item.ax = cx + udgc_pkg::coord_t'(ax_hi);
		push_item.ay = cy + udgc_pkg::coord_t'(ay_hi);
		push_item.bx = cx + udgc_pkg::coord_t'(!ax_hi);
		push_item.by = cy + udgc_pkg::coord_t'(!ay_hi);
		push_item.in_a = d2_a <= udgc_pkg::D2_ONE;
		push_item.in_b = d2_b <= udgc_pkg::D2_ONE;
		push_item.epoch = epoch_s1;
		push_item.act = !drop;
		push_item.wipe = wipe_s1;
	end

	assign push = valid_s1 && !q_full && (!drop || wipe_s1);

endmodule

// ===== rtl/udgc_queue.sv =====
module udgc_queue (
	input logic clk,
	input logic arst_n,
	input logic push,
	input udgc_pkg::cand_t push_item,
	input logic pop,
	output udgc_pkg::cand_t head,
	output logic head_valid,
	output logic full
);

	udgc_pkg::cand_t slots_q [udgc_pkg::Q_DEPTH];
	logic [udgc_pkg::Q_PTR_W-1:0] wr_ptr_q;
	logic [udgc_pkg::Q_PTR_W-1:0] rd_ptr_q;
	logic [udgc_pkg::Q_CNT_W-1:0] cnt_q;

	assign head = slots_q[rd_ptr_q];
	assign head_valid = cnt_q != '0;
	assign full = cnt_q == udgc_pkg::Q_CNT_W'(udgc_pkg::Q_DEPTH);

	// pointers and fill count
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			cnt_q <= '0;
		end else begin
			if (push) begin
				wr_ptr_q <= wr_ptr_q + 1'b1;
			end
			if (pop) begin
				rd_ptr_q <= rd_ptr_q + 1'b1;
			end
			if (push && !pop) begin
				cnt_q <= cnt_q + 1'b1;
			end else if (pop && !push) begin
				cnt_q <= cnt_q - 1'b1;
			end
		end
	end

	// slot storage
	always_ff @(posedge clk) begin
		if (push) begin
			slots_q[wr_ptr_q] <= push_item;
		end
	end

endmodule

// ===== rtl/udgc_back.sv =====
module udgc_back (
	input logic clk,
	input logic arst_n,
	input udgc_pkg::cand_t head,
	input logic head_valid,
	output logic pop,
	output logic wiping,
	output logic out_valid,
	input logic out_stall,
	output logic [udgc_pkg::COORD_W-1:0] center_x,
	output logic [udgc_pkg::COORD_W-1:0] center_y
);

	udgc_pkg::bk_state_t state_q;
	udgc_pkg::bk_state_t state_n;
	udgc_pkg::addr_t wipe_cnt_q;
	logic wipe_done_q;

	udgc_pkg::epoch_t map_q [udgc_pkg::MAP_DEPTH];
	udgc_pkg::epoch_t rd_a_q;
	udgc_pkg::epoch_t rd_b_q;

	logic valid_s2;
	udgc_pkg::cand_t item_s2;
	logic fwd_v_q;
	udgc_pkg::addr_t fwd_addr_q;
	udgc_pkg::epoch_t fwd_tag_q;

	logic out_valid_q;
	udgc_pkg::coord_t cx_q;
	udgc_pkg::coord_t cy_q;

	logic out_free;
	logic fire;
	logic s2_free;
	logic head_ok;
	logic start_wipe;
	logic load;
	udgc_pkg::addr_t ia_s2;
	udgc_pkg::addr_t ib_s2;
	udgc_pkg::epoch_t tag_a;
	udgc_pkg::epoch_t tag_b;
	logic mark_a;
	logic mark_b;
	logic sel_b;
	logic emit;
	logic wr_en;
	udgc_pkg::addr_t wr_addr;

	// stage flow
	assign out_free = !out_valid_q || !out_stall;
	assign fire = valid_s2 && out_free;
	assign s2_free = !valid_s2 || fire;
	assign head_ok = head_valid && (!head.wipe || wipe_done_q);

	// next state
	always_comb begin
		state_n = state_q;
		case (state_q)
			udgc_pkg::BK_WIPE: begin
				if (wipe_cnt_q == udgc_pkg::WIPE_LAST) begin
					state_n = udgc_pkg::BK_RUN;
				end
			end
			udgc_pkg::BK_RUN: begin
				if (start_wipe) begin
					state_n = udgc_pkg::BK_WIPE;
				end
			end
			default: state_n = udgc_pkg::BK_WIPE;
		endcase
	end

	// state outputs
	always_comb begin
		wiping = 1'b0;
		pop = 1'b0;
		start_wipe = 1'b0;
		case (state_q)
			udgc_pkg::BK_WIPE: begin
				wiping = 1'b1;
			end
			udgc_pkg::BK_RUN: begin
				pop = head_ok && s2_free;
				start_wipe = head_valid && head.wipe && !wipe_done_q && !valid_s2;
			end
			default: wiping = 1'b1;
		endcase
	end

	assign load = pop && head.act;

	// mark lookup, the write landing on the load edge is forwarded
	assign ia_s2 = {item_s2.ay, item_s2.ax};
	assign ib_s2 = {item_s2.by, item_s2.bx};
	assign tag_a = (fwd_v_q && fwd_addr_q == ia_s2) ? fwd_tag_q : rd_a_q;
	assign tag_b = (fwd_v_q && fwd_addr_q == ib_s2) ? fwd_tag_q : rd_b_q;
	assign mark_a = tag_a == item_s2.epoch;
	assign mark_b = tag_b == item_s2.epoch;

	// center choice
	always_comb begin
		if (item_s2.in_a && !item_s2.in_b) begin
			sel_b = 1'b0;
			emit = !mark_a;
		end else if (!item_s2.in_a && item_s2.in_b) begin
			sel_b = 1'b1;
			emit = !mark_b;
		end else begin
			sel_b = 1'b0;
			emit = !mark_a && !mark_b;
		end
	end

	assign wr_en = fire && emit;
	assign wr_addr = sel_b ? ib_s2 : ia_s2;

	// control registers
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= udgc_pkg::BK_WIPE;
			wipe_cnt_q <= '0;
			wipe_done_q <= 1'b0;
			valid_s2 <= 1'b0;
			fwd_v_q <= 1'b0;
			out_valid_q <= 1'b0;
		end else begin
			state_q <= state_n;
			if (wiping) begin
				wipe_cnt_q <= wipe_cnt_q + 1'b1;
			end
			if (wiping && wipe_cnt_q == udgc_pkg::WIPE_LAST) begin
				wipe_done_q <= head_valid;
			end else if (pop) begin
				wipe_done_q <= 1'b0;
			end
			if (s2_free) begin
				valid_s2 <= load;
			end
			if (load) begin
				fwd_v_q <= wr_en;
			end
			if (out_free) begin
				out_valid_q <= wr_en;
			end
		end
	end

	// stage and result payload
	always_ff @(posedge clk) begin
		if (load) begin
			item_s2 <= head;
			fwd_addr_q <= wr_addr;
			fwd_tag_q <= item_s2.epoch;
		end
		if (wr_en) begin
			cx_q <= sel_b ? item_s2.bx : item_s2.ax;
			cy_q <= sel_b ? item_s2.by : item_s2.ay;
		end
	end

	// center map: epoch tag per grid corner, two reads and one write
	always_ff @(posedge clk) begin
		if (wiping) begin
			map_q[wipe_cnt_q] <= '0;
		end else if (wr_en) begin
			map_q[wr_addr] <= item_s2.epoch;
		end
		if (load) begin
			rd_a_q <= map_q[{head.ay, head.ax}];
			rd_b_q <= map_q[{head.by, head.bx}];
		end
	end

	assign out_valid = out_valid_q;
	assign center_x = cx_q;
	assign center_y = cy_q;

endmodule

// ===== rtl/unit_disk_grid_cover.sv =====
// Greedy unit disk cover on the even-sum grid corners. Sustained rate is one point
// per cycle while out_stall is low and no clearing pass runs; a point passes through the
// input register, queue, map lookup and output register. The chosen-center map is a
// 4096-entry memory of 8-bit epoch tags with two read ports and one write port;
// new_set moves to a fresh epoch instead of clearing it. After reset a clearing
// pass over all 4096 entries runs with in_stall high, and every 255th new_set causes
// the same pass once earlier points have left the map stage.
module unit_disk_grid_cover (
	input logic clk,
	input logic arst_n,
	input logic in_valid,
	output logic in_stall,
	input logic new_set,
	input logic [udgc_pkg::PT_W-1:0] point_x,
	input logic [udgc_pkg::PT_W-1:0] point_y,
	output logic out_valid,
	input logic out_stall,
	output logic [udgc_pkg::COORD_W-1:0] center_x,
	output logic [udgc_pkg::COORD_W-1:0] center_y
);

	logic wiping;
	logic q_full;
	logic push;
	udgc_pkg::cand_t push_item;
	logic pop;
	udgc_pkg::cand_t head;
	logic head_valid;

	// classify points
	udgc_front u_front (
		.clk(clk),
		.arst_n(arst_n),
		.in_valid(in_valid),
		.in_stall(in_stall),
		.new_set(new_set),
		.point_x(point_x),
		.point_y(point_y),
		.wiping(wiping),
		.q_full(q_full),
		.push(push),
		.push_item(push_item)
	);

	// decoupling queue
	udgc_queue u_queue (
		.clk(clk),
		.arst_n(arst_n),
		.push(push),
		.push_item(push_item),
		.pop(pop),
		.head(head),
		.head_valid(head_valid),
		.full(q_full)
	);

	// map lookup and result
	udgc_back u_back (
		.clk(clk),
		.arst_n(arst_n),
		.head(head),
		.head_valid(head_valid),
		.pop(pop),
		.wiping(wiping),
		.out_valid(out_valid),
		.out_stall(out_stall),
		.center_x(center_x),
		.center_y(center_y)
	);

endmodule

// ===== rtl/udgc_checker.sv =====
module udgc_checker (
	input logic clk,
	input logic arst_n,
	input logic in_stall,
	input logic out_valid,
	input logic out_stall,
	input logic [udgc_pkg::COORD_W-1:0] center_x,
	input logic [udgc_pkg::COORD_W-1:0] center_y
);

	// a stalled result holds
	a_out_hold: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && out_stall |=> out_valid && $stable(center_x) && $stable(center_y))
		else $error("stalled result changed");

	// every center has an even coordinate sum
	a_even_center: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid |-> center_x[0] == center_y[0])
		else $error("center off the even diagonal");

	// map clearing holds off input right after reset
	a_reset_clear: assert property (@(posedge clk) disable iff (!arst_n)
		$rose(arst_n) |-> in_stall ##1 in_stall)
		else $error("input taken during map clearing");

	// no result can appear right after reset
	a_reset_quiet: assert property (@(posedge clk) disable iff (!arst_n)
		$rose(arst_n) |-> !out_valid ##1 !out_valid)
		else $error("result without a point");

endmodule

bind unit_disk_grid_cover udgc_checker u_chk (.*);

// ===== sim/unit_disk_grid_cover_tb.sv =====
`timescale 1ns / 100ps

module unit_disk_grid_cover_tb;

	typedef struct {
		bit new_set;
		logic [udgc_pkg::PT_W-1:0] x;
		logic [udgc_pkg::PT_W-1:0] y;
	} point_t;

	typedef struct {
		udgc_pkg::coord_t x;
		udgc_pkg::coord_t y;
	} center_t;

	localparam int HOLD_CYCLES = 400;
	localparam int DRAIN_CYCLES = 64;
	localparam int RANDOM_POINTS = 400;
	localparam int MIN_SETS = 260;

	logic clk = 1'b0;
	logic arst_n = 1'b0;
	logic in_valid = 1'b0;
	logic in_stall;
	logic new_set = 1'b0;
	logic [udgc_pkg::PT_W-1:0] point_x = '0;
	logic [udgc_pkg::PT_W-1:0] point_y = '0;
	logic out_valid;
	logic out_stall = 1'b0;
	logic [udgc_pkg::COORD_W-1:0] center_x;
	logic [udgc_pkg::COORD_W-1:0] center_y;

	point_t pending_points[$];
	center_t chosen_centers_q[$];
	bit center_marked [udgc_pkg::MAP_DEPTH];
	int total_points = 1;
	int loaded_cnt = 0;
	int idle_phase = 0;
	int mismatch_cnt = 0;
	int hold_left = 0;
	bit hold_done = 1'b0;

	unit_disk_grid_cover u_top (
		.clk(clk),
		.arst_n(arst_n),
		.in_valid(in_valid),
		.in_stall(in_stall),
		.new_set(new_set),
		.point_x(point_x),
		.point_y(point_y),
		.out_valid(out_valid),
		.out_stall(out_stall),
		.center_x(center_x),
		.center_y(center_y)
	);

	always #2 clk = ~clk;

	// closed unit disk test in fixed point
	function automatic bit disk_covers(int px, int py, int cx, int cy);
		int dx;
		int dy;
		dx = px - (cx << udgc_pkg::FRAC_BITS);
		dy = py - (cy << udgc_pkg::FRAC_BITS);
		return (dx * dx + dy * dy) <= (1 << (2 * udgc_pkg::FRAC_BITS));
	endfunction

	// greedy choice of a center for one point, updates the marked-center map
	function automatic bit choose_center(input point_t p, output center_t c);
		int cx, cy, ax, ay, bx, by, sx, sy;
		bit in_a, in_b, fresh;
		c.x = '0;
		c.y = '0;
		if (p.new_set) begin
			foreach (center_marked[i])
				center_marked[i] = 1'b0;
		end
		cx = int'(p.x) >> udgc_pkg::FRAC_BITS;
		cy = int'(p.y) >> udgc_pkg::FRAC_BITS;
		if (cx >= udgc_pkg::GRID_SIDE - 1 || cy >= udgc_pkg::GRID_SIDE - 1)
			return 1'b0;
		// even-sum diagonal corners, in the fixed candidate order
		if (((cx + cy) & 1) == 0) begin
			ax = cx; ay = cy; bx = cx + 1; by = cy + 1;
		end else if ((cx & 1) == 0) begin
			ax = cx + 1; ay = cy; bx = cx; by = cy + 1;
		end else begin
			ax = cx; ay = cy + 1; bx = cx + 1; by = cy;
		end
		in_a = disk_covers(p.x, p.y, ax, ay);
		in_b = disk_covers(p.x, p.y, bx, by);
		if (in_a && !in_b) begin
			sx = ax; sy = ay;
			fresh = !center_marked[ay * udgc_pkg::GRID_SIDE + ax];
		end else if (!in_a && in_b) begin
			sx = bx; sy = by;
			fresh = !center_marked[by * udgc_pkg::GRID_SIDE + bx];
		end else begin
			sx = ax; sy = ay;
			fresh = !center_marked[ay * udgc_pkg::GRID_SIDE + ax] &&
				!center_marked[by * udgc_pkg::GRID_SIDE + bx];
		end
		if (!fresh)
			return 1'b0;
		center_marked[sy * udgc_pkg::GRID_SIDE + sx] = 1'b1;
		c.x = udgc_pkg::coord_t'(sx);
		c.y = udgc_pkg::coord_t'(sy);
		return 1'b1;
	endfunction

	function automatic int sender_idle_pct(int ph);
		return (ph == 0) ? 32 : (ph == 1) ? 82 : 0;
	endfunction

	function automatic int receiver_idle_pct(int ph);
		return (ph == 0) ? 82 : (ph == 1) ? 32 : 0;
	endfunction

	// point driver: predicts on acceptance, loads the next item when free
	always @(posedge clk or negedge arst_n) begin
		point_t p;
		center_t c;
		if (!arst_n) begin
			in_valid <= 1'b0;
			new_set <= 1'b0;
			point_x <= '0;
			point_y <= '0;
		end else begin
			if (in_valid && !in_stall) begin
				p.new_set = new_set;
				p.x = point_x;
				p.y = point_y;
				if (choose_center(p, c))
					chosen_centers_q.insert(chosen_centers_q.size(), c);
			end
			if (!in_valid || !in_stall) begin
				if (pending_points.size() != 0 &&
						$urandom_range(0, 99) >= sender_idle_pct(idle_phase)) begin
					p = pending_points.pop_front();
					in_valid <= 1'b1;
					new_set <= p.new_set;
					point_x <= p.x;
					point_y <= p.y;
					loaded_cnt <= loaded_cnt + 1;
					idle_phase <= (3 * (loaded_cnt + 1) < total_points) ? 0 :
						(3 * (loaded_cnt + 1) < 2 * total_points) ? 1 : 2;
				end else begin
					in_valid <= 1'b0;
				end
			end
		end
	end

	// result monitor: checks each center and drives out_stall
	always @(posedge clk or negedge arst_n) begin
		center_t c;
		if (!arst_n) begin
			out_stall <= 1'b0;
		end else begin
			if (out_valid && !out_stall) begin
				if (chosen_centers_q.size() == 0) begin
					$display("%0t unexpected center: expected none actual (%0d,%0d)",
						$time, center_x, center_y);
					mismatch_cnt++;
				end else begin
					c = chosen_centers_q.pop_front();
					if (center_x !== c.x) begin
						$display("%0t center_x mismatch: expected %0d actual %0d",
							$time, c.x, center_x);
						mismatch_cnt++;
					end
					if (center_y !== c.y) begin
						$display("%0t center_y mismatch: expected %0d actual %0d",
							$time, c.y, center_y);
						mismatch_cnt++;
					end
				end
			end
			// one long hold-off early in the last phase so the block backs up
			if (hold_left > 0) begin
				out_stall <= 1'b1;
				hold_left <= hold_left - 1;
			end else if (idle_phase == 2 && !hold_done) begin
				hold_done <= 1'b1;
				hold_left <= HOLD_CYCLES - 1;
				out_stall <= 1'b1;
			end else begin
				out_stall <= ($urandom_range(0, 99) < receiver_idle_pct(idle_phase));
			end
		end
	end

	task automatic add_point(bit ns, int x, int y);
		point_t p;
		p.new_set = ns;
		p.x = udgc_pkg::PT_W'(x);
		p.y = udgc_pkg::PT_W'(y);
		pending_points.insert(pending_points.size(), p);
	endtask

	function automatic int near_offset();
		return $urandom_range(0, 2) * udgc_pkg::FRAC_ONE +
			(($urandom_range(0, 3) == 0) ? 0 : $urandom_range(0, udgc_pkg::FRAC_ONE - 1));
	endfunction

	// stimulus and end of run
	initial begin
		int kept_points;
		int set_cnt;
		int len;
		int base_x;
		int base_y;
		int x;
		int y;
		bit ns;

		// directed: corners, boundaries, every cell parity, grid edge, output extremes
		add_point(1'b1, 0, 0);
		add_point(1'b0, 0, 0);
		add_point(1'b0, 128, 128);
		add_point(1'b0, 255, 255);
		add_point(1'b0, 256, 0);
		add_point(1'b0, 0, 256);
		add_point(1'b0, 256, 5);
		add_point(1'b1, 16383, 16383);
		add_point(1'b0, 16127, 16127);
		add_point(1'b0, 16128, 0);
		add_point(1'b0, 0, 16128);
		add_point(1'b0, 16127, 0);
		add_point(1'b0, 0, 16127);
		add_point(1'b0, 300, 10);
		add_point(1'b0, 520, 770);
		add_point(1'b0, 770, 520);
		add_point(1'b1, 300, 10);
		add_point(1'b0, 8191, 8192);
		add_point(1'b0, 5461, 10922);
		add_point(1'b0, 10922, 5461);

		// random: mostly short sets of nearby points, some noise across the whole range
		kept_points = 0;
		set_cnt = 0;
		while (kept_points < RANDOM_POINTS || set_cnt < MIN_SETS) begin
			if ($urandom_range(0, 99) < 10) begin
				ns = $urandom_range(0, 1);
				x = $urandom_range(0, 16383);
				y = $urandom_range(0, 16383);
				add_point(ns, x, y);
				set_cnt += ns;
				if ((x >> udgc_pkg::FRAC_BITS) < udgc_pkg::GRID_SIDE - 1 &&
						(y >> udgc_pkg::FRAC_BITS) < udgc_pkg::GRID_SIDE - 1)
					kept_points++;
			end else begin
				len = ($urandom_range(0, 99) < 85) ? 1 : $urandom_range(2, 4);
				base_x = $urandom_range(0, udgc_pkg::GRID_SIDE - 3);
				base_y = $urandom_range(0, udgc_pkg::GRID_SIDE - 3);
				for (int k = 0; k < len; k++) begin
					x = base_x * udgc_pkg::FRAC_ONE + near_offset();
					y = base_y * udgc_pkg::FRAC_ONE + near_offset();
					add_point(k == 0, x, y);
					if ((x >> udgc_pkg::FRAC_BITS) < udgc_pkg::GRID_SIDE - 1 &&
							(y >> udgc_pkg::FRAC_BITS) < udgc_pkg::GRID_SIDE - 1)
						kept_points++;
				end
				set_cnt++;
			end
		end
		total_points = pending_points.size();

		repeat (8) @(posedge clk);
		arst_n <= 1'b1;

		while (pending_points.size() != 0 || in_valid)
			@(posedge clk);
		while (chosen_centers_q.size() != 0)
			@(posedge clk);
		repeat (DRAIN_CYCLES) @(posedge clk);

		if (mismatch_cnt == 0)
			$display("status: pass");
		else
			$display("status: fail");
		$finish;
	end

	// run limit
	initial begin
		#2000000;
		$display("status: fail");
		$finish;
	end

endmodule
